// ===== hw/rtl/i2crb_pkg.sv =====
// Shared types and codes for the I2C slave register bank.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2crb_pkg;

    localparam logic [2:0] MODE_WRITE_START   = 3'd0;
    localparam logic [2:0] MODE_READ_START    = 3'd1;
    localparam logic [2:0] MODE_BYTE_RECEIVED = 3'd2;
    localparam logic [2:0] MODE_BYTE_SENT     = 3'd3;
    localparam logic [2:0] MODE_ACK_FAILURE   = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RANGE    = 2'd1;
    localparam logic [1:0] STATUS_PAST_END = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FETCH,
        ST_FETCH_DATA,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] write_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       byte_accepted;
        logic [1:0] status;
    } out_item_t;

    // memory port strobes from the sequencer
    typedef struct packed {
        logic wr;
        logic rd;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_slave_register_bank_core.sv =====
// I2C slave register bank: sequencer, shared 9-bit adder/comparator, and storage.
// Each event runs EXEC then DONE; a register read adds FETCH and, in range, FETCH_DATA; a commit
// adds CHECK and, in range, a COPY_RD/COPY_WR pair per data byte through the shared adder.
// One transfer at a time. The result register lets the next transfer be taken while a result
// waits. Reset clears the bank, pointer, counters and output; no clearing pass.
`default_nettype none

module i2c_slave_register_bank_core #(
    parameter int NUM_REGS     = 16,
    parameter int BUFFER_BYTES = 17
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  i2crb_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  wire                  out_ready,
    output i2crb_pkg::out_item_t out_item
);
    import i2crb_pkg::*;

    localparam int DB = BUFFER_BYTES - 1;
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int BW = (DB > 1) ? $clog2(DB) : 1;
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    state_t         state_reg, state_next;
    logic [2:0]     mode_reg, mode_next;
    logic [7:0]     byte_reg, byte_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [7:0]     sent_reg, sent_next;
    logic [7:0]     rp_reg, rp_next;
    logic [7:0]     ptr_reg, ptr_next;
    logic [7:0]     idx_reg, idx_next;
    logic [8:0]     addr_reg, addr_next;
    logic [7:0]     data_reg, data_next;
    logic           acc_reg, acc_next;
    logic [1:0]     stat_reg, stat_next;
    out_item_t      out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    // shared adder
    logic [7:0]     op_a, op_b;
    logic [8:0]     sum;
    logic [CW-1:0]  nbytes_w;
    logic [7:0]     nbytes;

    mem_ctl_t       bank_ctl, buf_ctl;
    logic [7:0]     bank_rdata, buf_rdata;
    logic [RW-1:0]  bank_raddr;
    logic [BW-1:0]  buf_waddr;

    assign nbytes_w = count_reg - CW'(1);
    assign nbytes   = 8'(nbytes_w);
    assign sum      = {1'b0, op_a} + {1'b0, op_b};
    assign buf_waddr  = BW'(nbytes_w);
    assign bank_raddr = sum[RW-1:0];

    i2crb_regfile #(
        .NUM_REGS (NUM_REGS),
        .RW       (RW)
    ) u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bank_ctl),
        .waddr (addr_reg[RW-1:0]),
        .wdata (buf_rdata),
        .raddr (bank_raddr),
        .rdata (bank_rdata)
    );

    i2crb_bufmem #(
        .DEPTH (DB),
        .BW    (BW)
    ) u_bufmem (
        .clk   (clk),
        .ctl   (buf_ctl),
        .waddr (buf_waddr),
        .wdata (byte_reg),
        .raddr (idx_reg[BW-1:0]),
        .rdata (buf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sent_reg      <= '0;
            rp_reg        <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sent_reg      <= sent_next;
            rp_reg        <= rp_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        byte_reg <= byte_next;
        idx_reg  <= idx_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        acc_reg  <= acc_next;
        stat_reg <= stat_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        byte_next      = byte_reg;
        count_next     = count_reg;
        sent_next      = sent_reg;
        rp_next        = rp_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        acc_next       = acc_reg;
        stat_next      = stat_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        bank_ctl       = '0;
        buf_ctl        = '0;
        op_a           = ptr_reg;
        op_b           = idx_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = in_item.mode;
                    byte_next  = in_item.write_byte;
                    data_next  = 8'd0;
                    acc_next   = 1'b0;
                    stat_next  = STATUS_OK;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (mode_reg)
                    MODE_WRITE_START:
                        count_next = '0;
                    MODE_READ_START:
                    begin
                        sent_next  = 8'd0;
                        rp_next    = ptr_reg;
                        state_next = ST_FETCH;
                    end
                    MODE_BYTE_RECEIVED:
                    begin
                        if (count_reg < CW'(BUFFER_BYTES))
                        begin
                            if (count_reg == '0)
                                ptr_next = byte_reg;
                            else
                                buf_ctl.wr = 1'b1;
                            count_next = count_reg + CW'(1);
                            acc_next   = 1'b1;
                            // filling byte commits in the same transfer
                            if (count_reg == CW'(BUFFER_BYTES - 1))
                                state_next = ST_CHECK;
                        end
                    end
                    MODE_BYTE_SENT:
                    begin
                        sent_next  = sent_reg + 8'd1;
                        state_next = ST_FETCH;
                    end
                    MODE_ACK_FAILURE:
                    begin
                        if (sent_reg != 8'd0)
                            sent_next = sent_reg - 8'd1;
                        else if (count_reg > CW'(1))
                            state_next = ST_CHECK;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_CHECK:
            begin
                op_a = ptr_reg;
                op_b = nbytes;
                if (sum > 9'(NUM_REGS))
                begin
                    stat_next  = STATUS_RANGE;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = 8'd0;
                    state_next = ST_COPY_RD;
                end
            end
            ST_COPY_RD:
            begin
                op_a       = ptr_reg;
                op_b       = idx_reg;
                addr_next  = sum;
                buf_ctl.rd = 1'b1;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                bank_ctl.wr = 1'b1;
                idx_next    = idx_reg + 8'd1;
                if ({1'b0, idx_reg} + 9'd1 == {1'b0, nbytes})
                    state_next = ST_DONE;
                else
                    state_next = ST_COPY_RD;
            end
            ST_FETCH:
            begin
                op_a = rp_reg;
                op_b = sent_reg;
                if (sum >= 9'(NUM_REGS))
                begin
                    stat_next  = STATUS_PAST_END;
                    state_next = ST_DONE;
                end
                else
                begin
                    bank_ctl.rd = 1'b1;
                    state_next  = ST_FETCH_DATA;
                end
            end
            ST_FETCH_DATA:
            begin
                data_next  = bank_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.read_data     = data_reg;
                    out_next.byte_accepted = acc_reg;
                    out_next.status        = stat_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // bank writes only land inside the register range
    a_bank_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        bank_ctl.wr |-> addr_reg < 9'(NUM_REGS))
        else $error("bank write address out of range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUFFER_BYTES))
        else $error("receive count exceeds buffer size");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transfer did not start execution");

    a_copy_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY_WR) |-> ({1'b0, idx_reg} < {1'b0, nbytes}))
        else $error("copy index beyond buffered bytes");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/i2crb_regfile.sv =====
// Register bank storage: one write port, one registered read port.
// Per-entry valid flags make never-written registers read as zero. Uses i2crb_pkg.
`default_nettype none

module i2crb_regfile #(
    parameter int NUM_REGS = 16,
    parameter int RW       = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  i2crb_pkg::mem_ctl_t  ctl,
    input  wire  [RW-1:0]        waddr,
    input  wire  [7:0]           wdata,
    input  wire  [RW-1:0]        raddr,
    output logic [7:0]           rdata
);
    import i2crb_pkg::*;

    logic [7:0]          mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [7:0]          rdata_reg;
    logic                rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
            mem[waddr] <= wdata;
        if (ctl.rd)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr)
                valid_reg[waddr] <= 1'b1;
            if (ctl.rd)
                rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'd0;

endmodule

`default_nettype wire

// ===== hw/rtl/i2crb_bufmem.sv =====
// Receive buffer for the data bytes that follow the pointer byte.
// One write port, one registered read port. Uses i2crb_pkg.
`default_nettype none

module i2crb_bufmem #(
    parameter int DEPTH = 16,
    parameter int BW    = 4
) (
    input  wire                  clk,
    input  i2crb_pkg::mem_ctl_t  ctl,
    input  wire  [BW-1:0]        waddr,
    input  wire  [7:0]           wdata,
    input  wire  [BW-1:0]        raddr,
    output logic [7:0]           rdata
);
    import i2crb_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
            mem[waddr] <= wdata;
        if (ctl.rd)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
